@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds across reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/smpd_pkg.sv @@
`default_nettype none

package smpd_pkg;

    // Position and scale widths
    localparam int POS_BITS   = 12;
    localparam int SCALE_BITS = 16;
    localparam int DELTA_BITS = 9;   // signed, holds +128 after negation
    localparam int SUM_BITS   = POS_BITS + 2;
    localparam int PROD_BITS  = POS_BITS + SCALE_BITS;

    // Configuration port
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 5;

    // Reset values of the configuration registers and position
    localparam logic [POS_BITS-1:0]   WIDTH_RST  = POS_BITS'(640);
    localparam logic [POS_BITS-1:0]   HEIGHT_RST = POS_BITS'(480);
    localparam logic [SCALE_BITS-1:0] XSCALE_RST = SCALE_BITS'(102);
    localparam logic [SCALE_BITS-1:0] YSCALE_RST = SCALE_BITS'(136);
    localparam logic [SCALE_BITS-1:0] ABS_MAX    = '1;

    // Bit positions inside the 7-bit payload of a received byte
    localparam int SYNC_POS  = 6;
    localparam int LEFT_POS  = 5;
    localparam int RIGHT_POS = 4;

    // Output tdata layout
    localparam int OUT_MOVED  = 0;
    localparam int OUT_LDOWN  = 1;
    localparam int OUT_LUP    = 2;
    localparam int OUT_RDOWN  = 3;
    localparam int OUT_RUP    = 4;
    localparam int OUT_BITS   = 64;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_SWAP_BUTTONS  = 3'd0,
        REG_MIRROR_X      = 3'd1,
        REG_MIRROR_Y      = 3'd2,
        REG_ROTATE_AXES   = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_X_SCALE       = 3'd6,
        REG_Y_SCALE       = 3'd7
    } t_reg_idx;

    // Packet framing state
    typedef enum logic [2:0] {
        PH_SYNC  = 3'b001,
        PH_XBYTE = 3'b010,
        PH_YBYTE = 3'b100
    } t_phase;

    // Decoded packet handed to the scaling stage
    typedef struct packed {
        logic                moved;
        logic                left_down;
        logic                left_up;
        logic                right_down;
        logic                right_up;
        logic [POS_BITS-1:0] cursor_x;
        logic [POS_BITS-1:0] cursor_y;
    } t_evt;

endpackage

`default_nettype wire

@@ src/serial_mouse_packet_decoder.sv @@
`default_nettype none

// Serial mouse packet decoder. Takes one received UART byte per transfer on
// s_axis (bit 7 ignored), frames three-byte packets on the sync bit, and
// returns one result transfer per complete packet on m_axis: move flag,
// left/right down and release events, the clamped cursor position and that
// position scaled by x_scale/y_scale (saturated at 65535). A byte can be taken
// every cycle while no stalled result holds s_axis_tready low. Each byte lands
// in an input register. One pass of decode, clamp and a 12x16 multiply per axis
// then loads the result register, from which a result is offered on m_axis.
// That single pass sets the cycle time. While a result waits on m_axis, the
// input register still takes one more byte; after that s_axis_tready drops
// until the result is taken. Registers sit on the APB port at byte address
// 4*index. Writing screen_width or screen_height recenters that axis.
// Configuration may only change while no packet is in flight.
module serial_mouse_packet_decoder
    import smpd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // stream in: tdata = rx_byte[7:0]
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [7:0]               s_axis_tdata,
    // stream out: tdata = moved[0], left_down[1], left_up[2], right_down[3],
    // right_up[4], cursor_x[16:5], cursor_y[28:17], abs_x[44:29],
    // abs_y[60:45], zero[63:61]
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [OUT_BITS-1:0]           m_axis_tdata,
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    // configuration registers
    logic                  r_swap, r_mirror_x, r_mirror_y, r_rotate;
    logic [POS_BITS-1:0]   r_width, r_height;
    logic [SCALE_BITS-1:0] r_x_scale, r_y_scale;

    // framing and tracking state
    t_phase                r_phase, n_phase;
    logic [5:0]            r_head, n_head;
    logic [5:0]            r_xb, n_xb;
    logic                  r_left_was, r_right_was;
    logic [POS_BITS-1:0]   r_pos_x, r_pos_y;

    // input and result registers
    logic                  r0_valid, r1_valid;
    logic [6:0]            r0_byte;
    t_evt                  r1_evt, n_evt;
    logic [SCALE_BITS-1:0] r1_abs_x, r1_abs_y;

    logic                  ready1, adv0;
    logic                  cfg_wr;
    t_reg_idx              cfg_idx;
    logic                  emit;

    logic                  sync;
    logic                  left, right;
    logic [7:0]            dx_raw, dy_raw;
    logic signed [DELTA_BITS-1:0] dx_m, dy_m, dx, dy;
    logic [POS_BITS-1:0]   nx_pos, ny_pos;
    logic [PROD_BITS-1:0]  prod_x, prod_y;

    // Stall chain from the output back to the input
    assign ready1        = !r1_valid || m_axis_tready;
    assign s_axis_tready = !r0_valid || ready1;
    assign adv0          = r0_valid && ready1;

    // APB access
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[CFG_ADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_SWAP_BUTTONS:  prdata[0] = r_swap;
            REG_MIRROR_X:      prdata[0] = r_mirror_x;
            REG_MIRROR_Y:      prdata[0] = r_mirror_y;
            REG_ROTATE_AXES:   prdata[0] = r_rotate;
            REG_SCREEN_WIDTH:  prdata[POS_BITS-1:0] = r_width;
            REG_SCREEN_HEIGHT: prdata[POS_BITS-1:0] = r_height;
            REG_X_SCALE:       prdata[SCALE_BITS-1:0] = r_x_scale;
            REG_Y_SCALE:       prdata[SCALE_BITS-1:0] = r_y_scale;
        endcase
    end

    // Framing: a sync byte always restarts the packet
    assign sync = r0_byte[SYNC_POS];
    assign emit = !sync && (r_phase == PH_YBYTE);

    always_comb begin
        n_phase = r_phase;
        n_head  = r_head;
        n_xb    = r_xb;
        if (sync) begin
            n_head  = r0_byte[5:0];
            n_phase = PH_XBYTE;
        end else if (r_phase == PH_XBYTE) begin
            n_xb    = r0_byte[5:0];
            n_phase = PH_YBYTE;
        end else begin
            n_phase = PH_SYNC;
        end
    end

    // Buttons, optionally swapped
    assign left  = r_swap ? r_head[RIGHT_POS] : r_head[LEFT_POS];
    assign right = r_swap ? r_head[LEFT_POS]  : r_head[RIGHT_POS];

    // Deltas: high bits from the head byte
    assign dx_raw = {r_head[1:0], r_xb};
    assign dy_raw = {r_head[3:2], r0_byte[5:0]};
    assign dx_m   = r_mirror_x ? -$signed({dx_raw[7], dx_raw}) : $signed({dx_raw[7], dx_raw});
    assign dy_m   = r_mirror_y ? -$signed({dy_raw[7], dy_raw}) : $signed({dy_raw[7], dy_raw});
    assign dx     = r_rotate ? dy_m : dx_m;
    assign dy     = r_rotate ? dx_m : dy_m;

    // Move and clamp to 0..limit
    function automatic logic [POS_BITS-1:0] clamp_move(
        input logic [POS_BITS-1:0]          pos,
        input logic signed [DELTA_BITS-1:0] d,
        input logic [POS_BITS-1:0]          lim
    );
        logic signed [SUM_BITS-1:0] s;
        s = $signed({2'b00, pos}) + SUM_BITS'(d);
        if (s[SUM_BITS-1]) begin
            return '0;
        end else if (s[SUM_BITS-2:0] > {1'b0, lim}) begin
            return lim;
        end else begin
            return s[POS_BITS-1:0];
        end
    endfunction

    assign nx_pos = clamp_move(r_pos_x, dx, r_width);
    assign ny_pos = clamp_move(r_pos_y, dy, r_height);

    always_comb begin
        n_evt.moved      = (dx_raw != '0) || (dy_raw != '0);
        n_evt.left_down  = left;
        n_evt.left_up    = !left && r_left_was;
        n_evt.right_down = right;
        n_evt.right_up   = !right && r_right_was;
        n_evt.cursor_x   = nx_pos;
        n_evt.cursor_y   = ny_pos;
    end

    // Scaling of the new position
    assign prod_x = PROD_BITS'(nx_pos) * PROD_BITS'(r_x_scale);
    assign prod_y = PROD_BITS'(ny_pos) * PROD_BITS'(r_y_scale);

    // Config registers and decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap      <= 1'b0;
            r_mirror_x  <= 1'b0;
            r_mirror_y  <= 1'b0;
            r_rotate    <= 1'b0;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_x_scale   <= XSCALE_RST;
            r_y_scale   <= YSCALE_RST;
            r_phase     <= PH_SYNC;
            r_head      <= '0;
            r_xb        <= '0;
            r_left_was  <= 1'b0;
            r_right_was <= 1'b0;
            r_pos_x     <= WIDTH_RST >> 1;
            r_pos_y     <= HEIGHT_RST >> 1;
        end else begin
            if (adv0) begin
                r_phase <= n_phase;
                r_head  <= n_head;
                r_xb    <= n_xb;
                if (emit) begin
                    r_left_was  <= left;
                    r_right_was <= right;
                    r_pos_x     <= nx_pos;
                    r_pos_y     <= ny_pos;
                end
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_SWAP_BUTTONS: r_swap     <= pwdata[0];
                    REG_MIRROR_X:     r_mirror_x <= pwdata[0];
                    REG_MIRROR_Y:     r_mirror_y <= pwdata[0];
                    REG_ROTATE_AXES:  r_rotate   <= pwdata[0];
                    REG_SCREEN_WIDTH: begin
                        r_width <= pwdata[POS_BITS-1:0];
                        r_pos_x <= pwdata[POS_BITS-1:0] >> 1;
                    end
                    REG_SCREEN_HEIGHT: begin
                        r_height <= pwdata[POS_BITS-1:0];
                        r_pos_y  <= pwdata[POS_BITS-1:0] >> 1;
                    end
                    REG_X_SCALE:      r_x_scale <= pwdata[SCALE_BITS-1:0];
                    REG_Y_SCALE:      r_y_scale <= pwdata[SCALE_BITS-1:0];
                endcase
            end
        end
    end

    // Register valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r0_valid <= s_axis_tvalid;
            end
            if (ready1) begin
                r1_valid <= adv0 && emit;
            end
        end
    end

    // Register payloads
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r0_byte <= s_axis_tdata[6:0];
        end
        if (adv0 && emit) begin
            r1_evt   <= n_evt;
            r1_abs_x <= (prod_x[PROD_BITS-1:SCALE_BITS] != '0) ? ABS_MAX
                                                                : prod_x[SCALE_BITS-1:0];
            r1_abs_y <= (prod_y[PROD_BITS-1:SCALE_BITS] != '0) ? ABS_MAX
                                                                : prod_y[SCALE_BITS-1:0];
        end
    end

    // Output transfer
    assign m_axis_tvalid = r1_valid;
    assign m_axis_tdata  = {3'b000, r1_abs_y, r1_abs_x, r1_evt.cursor_y, r1_evt.cursor_x,
                            r1_evt.right_up, r1_evt.right_down, r1_evt.left_up,
                            r1_evt.left_down, r1_evt.moved};

endmodule

`default_nettype wire

@@ src/smpd_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module smpd_checker
    import smpd_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [OUT_BITS-1:0] m_axis_tdata,
    input wire logic                pready
);

    // a stalled result keeps its payload
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // a button cannot be held and released in the same packet
    `ASSERT_CLK(a_left_excl, i_clk, i_rst_n, m_axis_tvalid |-> !(m_axis_tdata[OUT_LDOWN] && m_axis_tdata[OUT_LUP]), "left down and up together")
    `ASSERT_CLK(a_right_excl, i_clk, i_rst_n, m_axis_tvalid |-> !(m_axis_tdata[OUT_RDOWN] && m_axis_tdata[OUT_RUP]), "right down and up together")

    // with the output empty nothing downstream can stall the input
    `ASSERT_CLK(a_in_free, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready && pready, "input blocked with empty output")

    // reset empties the pipeline
    `ASSERT_CLK_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result after reset")

endmodule

bind serial_mouse_packet_decoder smpd_checker u_smpd_checker (.*);

`default_nettype wire
